[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AST_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/crs_pkg.sv]
`timescale 1ns / 1ps
package crs_pkg;

  // Fraction bits of the segment position x and of the curve values.
  localparam int XB = 30;
  // Quotient bits formed in each divider stage.
  localparam int DIV_STEP = 2;
  localparam int NDIV = XB / DIV_STEP;

  typedef logic signed [33:0] q_t;

  localparam q_t ONE_X  = 34'sd1073741824;
  localparam q_t HALF_X = 34'sd536870912;
  localparam q_t SIN_C0 = 34'sd1686004129;
  localparam q_t SIN_C1 = -34'sd2757668350;
  localparam q_t SIN_C2 = 34'sd1234476520;
  localparam q_t EXP_K1 = 34'sd376888174;
  localparam q_t EXP_K2 = 34'sd696853650;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Request curve codes.
  localparam logic [2:0] MODE_HOLD  = 3'd0;
  localparam logic [2:0] MODE_LIN   = 3'd1;
  localparam logic [2:0] MODE_SINE  = 3'd2;
  localparam logic [2:0] MODE_EXP   = 3'd3;
  localparam logic [2:0] MODE_LOG   = 3'd4;
  localparam logic [2:0] MODE_SAT   = 3'd5;
  localparam logic [2:0] MODE_DECAY = 3'd6;

  // Ramp shape after exp and log are resolved.
  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_LIN,
    KIND_SINE,
    KIND_ENV
  } kind_t;

  // Per-item fields carried down the pipeline.
  typedef struct packed {
    kind_t              kind;
    logic               flip;
    logic signed [31:0] from_v;
    logic signed [31:0] to_v;
    logic               mul_en;
    logic signed [31:0] mul_v;
    logic               last;
  } ctl_t;

  // Q30 product rounded to nearest, ties upward.
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [67:0] p;
    p = a * b + (68'sd1 <<< (XB - 1));
    return q_t'(p >>> XB);
  endfunction

  // Clamp a ramp value to the unit interval.
  function automatic q_t clamp_unit(input q_t r);
    q_t res;
    res = r;
    if (r < 0) begin
      res = '0;
    end else if (r > ONE_X) begin
      res = ONE_X;
    end
    return res;
  endfunction

endpackage

[hw/rtl/curve_ramp_sample.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_ready  | mode, start, goal, position, duration, mul, last
// out_     | output    | out_valid / out_ready| sample_value, overflow, last
//
// One item enters per clock while the output is not stalled; the stages are the
// input stage, 15 divider stages at two quotient bits each, and eight curve and scaling stages.
// The divider forming position / duration sets the depth of the pipeline.
// rst_n is synchronous and clears only the stage valid bits.
// When the output holds an item that is not taken, the whole pipeline stalls.
`include "assert_macros.svh"
module curve_ramp_sample #(
  parameter int POS_BITS  = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_mode,
  input  logic signed [31:0]         in_start_value,
  input  logic signed [31:0]         in_goal_value,
  input  logic [POS_BITS-1:0]        in_position,
  input  logic [POS_BITS-1:0]        in_duration,
  input  logic                       in_mul_enable,
  input  logic signed [31:0]         in_mul_value,
  input  logic                       in_last_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_sample_value,
  output logic                       out_overflow,
  output logic                       out_last
);
  import crs_pkg::*;

  logic adv;

  // Entry: resolve the curve kind and direction.
  ctl_t ent_ctl;
  always_comb begin
    ent_ctl.kind   = KIND_HOLD;
    ent_ctl.flip   = 1'b0;
    ent_ctl.mul_en = in_mul_enable;
    ent_ctl.mul_v  = in_mul_value;
    ent_ctl.last   = in_last_in;
    case (in_mode)
      MODE_LIN:   ent_ctl.kind = KIND_LIN;
      MODE_SINE:  ent_ctl.kind = KIND_SINE;
      MODE_EXP: begin
        ent_ctl.kind = KIND_ENV;
        ent_ctl.flip = (in_start_value > in_goal_value);
      end
      MODE_LOG: begin
        ent_ctl.kind = KIND_ENV;
        ent_ctl.flip = (in_start_value < in_goal_value);
      end
      MODE_SAT: begin
        ent_ctl.kind = KIND_ENV;
        ent_ctl.flip = 1'b1;
      end
      MODE_DECAY: ent_ctl.kind = KIND_ENV;
      default:    ent_ctl.kind = KIND_HOLD;
    endcase
    // When flip is set (saturate always, exp and log by direction), the ramp runs from the goal back toward the start.
    ent_ctl.from_v = ent_ctl.flip ? in_goal_value : in_start_value;
    ent_ctl.to_v   = ent_ctl.flip ? in_start_value : in_goal_value;
  end

  // Divider pipeline: stage 0 is the input register.
  logic                vld_d_r  [0:NDIV];
  ctl_t                ctl_d_r  [0:NDIV];
  logic                xone_d_r [0:NDIV];
  logic [POS_BITS-1:0] dur_d_r  [0:NDIV];
  logic [POS_BITS-1:0] rem_d_r  [0:NDIV];
  logic [XB-1:0]       q_d_r    [0:NDIV];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r[0] <= 1'b0;
    end else if (adv) begin
      vld_d_r[0]  <= in_valid;
      ctl_d_r[0]  <= ent_ctl;
      xone_d_r[0] <= (in_duration == '0) || (in_position >= in_duration);
      dur_d_r[0]  <= in_duration;
      rem_d_r[0]  <= in_position;
      q_d_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [POS_BITS-1:0] rem_nxt;
    logic [XB-1:0]       q_nxt;

    // Two restoring division steps.
    always_comb begin
      logic [POS_BITS:0] rem2;
      rem_nxt = rem_d_r[k-1];
      q_nxt   = q_d_r[k-1];
      for (int s = 0; s < DIV_STEP; s++) begin
        rem2 = {rem_nxt, 1'b0};
        q_nxt = {q_nxt[XB-2:0], 1'b0};
        if (rem2 >= {1'b0, dur_d_r[k-1]}) begin
          rem2     = rem2 - {1'b0, dur_d_r[k-1]};
          q_nxt[0] = 1'b1;
        end
        rem_nxt = rem2[POS_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_d_r[k] <= 1'b0;
      end else if (adv) begin
        vld_d_r[k]  <= vld_d_r[k-1];
        ctl_d_r[k]  <= ctl_d_r[k-1];
        xone_d_r[k] <= xone_d_r[k-1];
        dur_d_r[k]  <= dur_d_r[k-1];
        rem_d_r[k]  <= rem_nxt;
        q_d_r[k]    <= q_nxt;
      end
    end
  end

  // Curve stages.
  logic vld_a_r, vld_b_r, vld_c_r, vld_d2_r, vld_e_r, vld_f_r, vld_g_r, vld_h_r;
  ctl_t ctl_a_r, ctl_b_r, ctl_c_r, ctl_d2_r, ctl_e_r, ctl_f_r, ctl_g_r, ctl_h_r;
  q_t   x_a_r, ex_a_r, u_a_r;
  q_t   x_b_r, ex_b_r, u_b_r, u2_b_r, x2_b_r, kx_b_r;
  q_t   x_c_r, u_c_r, u2_c_r, x2_c_r, kx_c_r, t1_c_r, x3_c_r, kx2_c_r;
  q_t   x_d_r, u_d_r, x2_d_r, x3_d_r, t2_d_r, x5_d_r, f_d_r;
  q_t   r_e_r;
  logic signed [31:0] v_f_r, v_g_r;
  logic signed [63:0] p_g_r;
  logic signed [31:0] sample_h_r;
  logic               ovf_h_r;

  q_t x_nxt, r_nxt;
  logic signed [31:0] v_nxt, sample_nxt;
  logic ovf_nxt;

  always_comb begin
    x_nxt = xone_d_r[NDIV] ? ONE_X : q_t'(q_d_r[NDIV]);
  end

  // Ramp selection at the end of the polynomial stages.
  always_comb begin
    q_t sine_v, env_v;
    sine_v = clamp_unit(HALF_X + qmul(u_d_r, t2_d_r));
    env_v  = clamp_unit(x3_d_r + qmul(x5_d_r - x2_d_r, f_d_r));
    case (ctl_d2_r.kind)
      KIND_LIN:  r_nxt = x_d_r;
      KIND_SINE: r_nxt = sine_v;
      KIND_ENV:  r_nxt = env_v;
      default:   r_nxt = '0;
    endcase
  end

  // Move from from_v toward to_v by the ramp fraction.
  always_comb begin
    logic signed [32:0] d;
    logic signed [66:0] tp;
    d = 33'(ctl_e_r.to_v) - 33'(ctl_e_r.from_v);
    tp = d * r_e_r + (67'sd1 <<< (XB - 1));
    v_nxt = ctl_e_r.from_v + 32'(tp >>> XB);
  end

  // When scaling is enabled, round the scaled value and saturate it to 32 bits; otherwise pass the value through.
  always_comb begin
    logic signed [63:0] sh;
    sh = (p_g_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    sample_nxt = v_g_r;
    ovf_nxt    = 1'b0;
    if (ctl_g_r.mul_en) begin
      if (sh > S32_MAX) begin
        sample_nxt = 32'(S32_MAX);
        ovf_nxt    = 1'b1;
      end else if (sh < S32_MIN) begin
        sample_nxt = 32'(S32_MIN);
        ovf_nxt    = 1'b1;
      end else begin
        sample_nxt = 32'(sh);
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r  <= 1'b0;
      vld_b_r  <= 1'b0;
      vld_c_r  <= 1'b0;
      vld_d2_r <= 1'b0;
      vld_e_r  <= 1'b0;
      vld_f_r  <= 1'b0;
      vld_g_r  <= 1'b0;
      vld_h_r  <= 1'b0;
    end else if (adv) begin
      vld_a_r  <= vld_d_r[NDIV];
      vld_b_r  <= vld_a_r;
      vld_c_r  <= vld_b_r;
      vld_d2_r <= vld_c_r;
      vld_e_r  <= vld_d2_r;
      vld_f_r  <= vld_e_r;
      vld_g_r  <= vld_f_r;
      vld_h_r  <= vld_g_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_a_r <= ctl_d_r[NDIV];
      x_a_r   <= x_nxt;
      ex_a_r  <= ctl_d_r[NDIV].flip ? (ONE_X - x_nxt) : x_nxt;
      u_a_r   <= x_nxt - HALF_X;

      ctl_b_r <= ctl_a_r;
      x_b_r   <= x_a_r;
      ex_b_r  <= ex_a_r;
      u_b_r   <= u_a_r;
      u2_b_r  <= qmul(u_a_r, u_a_r);
      x2_b_r  <= qmul(ex_a_r, ex_a_r);
      kx_b_r  <= qmul(ex_a_r, EXP_K1);

      ctl_c_r <= ctl_b_r;
      x_c_r   <= x_b_r;
      u_c_r   <= u_b_r;
      u2_c_r  <= u2_b_r;
      x2_c_r  <= x2_b_r;
      kx_c_r  <= kx_b_r;
      t1_c_r  <= SIN_C1 + qmul(u2_b_r, SIN_C2);
      x3_c_r  <= qmul(x2_b_r, ex_b_r);
      kx2_c_r <= qmul(x2_b_r, EXP_K2);

      ctl_d2_r <= ctl_c_r;
      x_d_r    <= x_c_r;
      u_d_r    <= u_c_r;
      x2_d_r   <= x2_c_r;
      x3_d_r   <= x3_c_r;
      t2_d_r   <= SIN_C0 + qmul(u2_c_r, t1_c_r);
      x5_d_r   <= qmul(x2_c_r, x3_c_r);
      f_d_r    <= kx_c_r + kx2_c_r;

      ctl_e_r <= ctl_d2_r;
      r_e_r   <= r_nxt;

      ctl_f_r <= ctl_e_r;
      v_f_r   <= v_nxt;

      ctl_g_r <= ctl_f_r;
      v_g_r   <= v_f_r;
      p_g_r   <= v_f_r * ctl_f_r.mul_v;

      ctl_h_r    <= ctl_g_r;
      sample_h_r <= sample_nxt;
      ovf_h_r    <= ovf_nxt;
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign adv              = !vld_h_r || out_ready;
  assign in_ready         = adv;
  assign out_valid        = vld_h_r;
  assign out_sample_value = sample_h_r;
  assign out_overflow     = ovf_h_r;
  assign out_last         = ctl_h_r.last;

  `AST_NOW(a_ovf_scaled, vld_h_r && ovf_h_r, ctl_h_r.mul_en, "overflow without scaling")
  `AST_NOW(a_x_range, vld_a_r, (x_a_r >= 0) && (x_a_r <= ONE_X), "x out of range")
  `AST_NOW(a_r_range, vld_e_r, (r_e_r >= 0) && (r_e_r <= ONE_X), "ramp out of range")
  `AST_NEXT(a_stall_hold, vld_h_r && !out_ready, vld_h_r && $stable(sample_h_r),
            "result lost in stall")

endmodule
